>>> hw/rtl/rhc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhc_pkg: shared types and helpers of the RGB to HSV converter
// Holds the work item passed from the classifier to the divider, the divider
// stage record and the restoring-division step shared by both quotients.
// ----------------------------------------------------------------------------
package rhc_pkg;

  localparam int ChanW        = 8;   // width of one color channel
  localparam int QuoW         = 16;  // width of hue and saturation
  localparam int RemW         = 11;  // holds 6 * chroma (up to 1530)
  localparam int StepsPerStage = 2;  // quotient bits resolved per stage
  localparam int DivStages    = QuoW / StepsPerStage;
  localparam int FifoDepth    = 4;
  localparam int FifoPtrW     = $clog2(FifoDepth);
  localparam int FifoCntW     = $clog2(FifoDepth + 1);

  // Classified pixel, ready for the dividers
  typedef struct packed {
    logic [RemW-1:0]  hue_num;    // sector position, 0 .. 6*chroma-1
    logic [RemW-1:0]  hue_den;    // 6 * chroma
    logic [ChanW-1:0] sat_num;    // chroma
    logic [ChanW-1:0] sat_den;    // value
    logic             hue_zero;   // gray pixel
    logic             sat_zero;   // black pixel
    logic             sat_full;   // chroma equals value, ratio is one
    logic [ChanW-1:0] brightness;
  } work_t;

  // One divider pipeline stage
  typedef struct packed {
    logic [RemW-1:0]  hue_rem;
    logic [RemW-1:0]  hue_den;
    logic [RemW-1:0]  sat_rem;
    logic [RemW-1:0]  sat_den;
    logic [QuoW-1:0]  hue_quo;
    logic [QuoW-1:0]  sat_quo;
    logic             hue_zero;
    logic             sat_zero;
    logic             sat_full;
    logic [ChanW-1:0] brightness;
  } div_t;

  // One restoring step: returns {quotient bit, next remainder}
  function automatic logic [RemW:0] div_step(input logic [RemW-1:0] rem,
                                              input logic [RemW-1:0] den);
    logic [RemW:0] twice;
    logic [RemW:0] diff;
    twice = {rem, 1'b0};
    diff  = twice - {1'b0, den};
    if (twice >= {1'b0, den}) begin
      return {1'b1, diff[RemW-1:0]};
    end else begin
      return {1'b0, twice[RemW-1:0]};
    end
  endfunction

  // Resolve StepsPerStage quotient bits of both divisions
  function automatic div_t div_stage(input div_t s);
    div_t          r;
    logic [RemW:0] h;
    logic [RemW:0] t;
    r = s;
    for (int i = 0; i < StepsPerStage; i++) begin
      h = div_step(r.hue_rem, r.hue_den);
      t = div_step(r.sat_rem, r.sat_den);
      r.hue_rem = h[RemW-1:0];
      r.sat_rem = t[RemW-1:0];
      r.hue_quo = {r.hue_quo[QuoW-2:0], h[RemW]};
      r.sat_quo = {r.sat_quo[QuoW-2:0], t[RemW]};
    end
    return r;
  endfunction

endpackage

>>> hw/rtl/rhc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhc_front: pixel classifier
// Accepts RGB pixels, finds value, chroma and hue sector, and registers the
// numerators and denominators for the divider back end.
// ----------------------------------------------------------------------------
module rhc_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        pix_valid_i,
  output logic                        pix_ready_o,
  input  logic [rhc_pkg::ChanW-1:0]   red_i,
  input  logic [rhc_pkg::ChanW-1:0]   green_i,
  input  logic [rhc_pkg::ChanW-1:0]   blue_i,
  output logic                        work_valid_o,
  input  logic                        work_ready_i,
  output rhc_pkg::work_t              work_o
);

  typedef enum logic [1:0] {
    SecRed,
    SecGreen,
    SecBlue
  } sector_e;

  sector_e                     sector;
  logic [rhc_pkg::ChanW-1:0]   val;
  logic [rhc_pkg::ChanW-1:0]   min_rg;
  logic [rhc_pkg::ChanW-1:0]   min_val;
  logic [rhc_pkg::ChanW-1:0]   chroma;
  logic [rhc_pkg::RemW-1:0]    turn;
  logic [rhc_pkg::RemW:0]      pos;
  rhc_pkg::work_t              work_d;
  rhc_pkg::work_t              work_q;
  logic                        valid_q;
  logic                        load;

  // Find largest channel and its sector, red winning ties over green
  always_comb begin
    if (red_i >= green_i && red_i >= blue_i) begin
      sector = SecRed;
      val    = red_i;
    end else if (green_i >= blue_i) begin
      sector = SecGreen;
      val    = green_i;
    end else begin
      sector = SecBlue;
      val    = blue_i;
    end
    min_rg  = (red_i < green_i) ? red_i : green_i;
    min_val = (min_rg < blue_i) ? min_rg : blue_i;
    chroma  = val - min_val;
  end

  // Position within the turn, wrapped by one turn when negative
  always_comb begin
    turn = {1'b0, chroma, 2'b00} + {2'b00, chroma, 1'b0};
    unique case (sector)
      SecRed:   pos = {4'b0, green_i} - {4'b0, blue_i};
      SecGreen: pos = {3'b0, chroma, 1'b0} + {4'b0, blue_i} - {4'b0, red_i};
      SecBlue:  pos = {2'b0, chroma, 2'b00} + {4'b0, red_i} - {4'b0, green_i};
      default:  pos = '0;
    endcase
    if (pos[rhc_pkg::RemW]) begin
      pos = pos + {1'b0, turn};
    end
  end

  always_comb begin
    work_d.hue_num    = pos[rhc_pkg::RemW-1:0];
    work_d.hue_den    = turn;
    work_d.sat_num    = chroma;
    work_d.sat_den    = val;
    work_d.hue_zero   = (chroma == '0);
    work_d.sat_zero   = (val == '0);
    work_d.sat_full   = (chroma == val) && (val != '0);
    work_d.brightness = val;
  end

  // Hold the classified pixel until the queue takes it
  assign pix_ready_o = !valid_q || work_ready_i;
  assign load        = pix_valid_i && pix_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pix_ready_o) begin
      valid_q <= pix_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      work_q <= work_d;
    end
  end

  assign work_valid_o = valid_q;
  assign work_o       = work_q;

endmodule

>>> hw/rtl/rhc_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhc_fifo: work queue
// Short first-in first-out queue between the classifier and the divider so
// either side can stall on its own.
// ----------------------------------------------------------------------------
module rhc_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  rhc_pkg::work_t  in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output rhc_pkg::work_t  out_data_o
);

  rhc_pkg::work_t                   mem_q [rhc_pkg::FifoDepth];
  logic [rhc_pkg::FifoPtrW-1:0]     wr_ptr_q;
  logic [rhc_pkg::FifoPtrW-1:0]     rd_ptr_q;
  logic [rhc_pkg::FifoCntW-1:0]     count_q;
  logic                             push;
  logic                             pop;

  assign in_ready_o  = (count_q != rhc_pkg::FifoCntW'(rhc_pkg::FifoDepth));
  assign out_valid_o = (count_q != '0);
  assign out_data_o  = mem_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == rhc_pkg::FifoPtrW'(rhc_pkg::FifoDepth - 1)) ?
                    '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == rhc_pkg::FifoPtrW'(rhc_pkg::FifoDepth - 1)) ?
                    '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // Store the entry
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_data_i;
    end
  end

endmodule

>>> hw/rtl/rhc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhc_back: divider back end
// Pipelined restoring dividers for hue and saturation, two quotient bits
// per stage, with per-stage valid bits and a ready chain for stalls.
// ----------------------------------------------------------------------------
module rhc_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       work_valid_i,
  output logic                       work_ready_o,
  input  rhc_pkg::work_t             work_i,
  output logic                       res_valid_o,
  input  logic                       res_ready_i,
  output logic [rhc_pkg::QuoW-1:0]   hue_o,
  output logic [rhc_pkg::QuoW-1:0]   saturation_o,
  output logic [rhc_pkg::ChanW-1:0]  brightness_o
);

  localparam int Last = rhc_pkg::DivStages - 1;

  rhc_pkg::div_t                  entry;
  rhc_pkg::div_t                  src   [rhc_pkg::DivStages];
  rhc_pkg::div_t                  stage_q [rhc_pkg::DivStages];
  logic [rhc_pkg::DivStages-1:0]  src_valid;
  logic [rhc_pkg::DivStages-1:0]  valid_q;
  logic [rhc_pkg::DivStages:0]    rdy;

  // Seed remainders with the numerators
  always_comb begin
    entry.hue_rem    = work_i.hue_num;
    entry.hue_den    = work_i.hue_den;
    entry.sat_rem    = rhc_pkg::RemW'(work_i.sat_num);
    entry.sat_den    = rhc_pkg::RemW'(work_i.sat_den);
    entry.hue_quo    = '0;
    entry.sat_quo    = '0;
    entry.hue_zero   = work_i.hue_zero;
    entry.sat_zero   = work_i.sat_zero;
    entry.sat_full   = work_i.sat_full;
    entry.brightness = work_i.brightness;
  end

  // Stage sources and ready chain from the output backwards
  always_comb begin
    src[0]       = entry;
    src_valid[0] = work_valid_i;
    for (int k = 1; k < rhc_pkg::DivStages; k++) begin
      src[k]       = stage_q[k-1];
      src_valid[k] = valid_q[k-1];
    end
    rdy[rhc_pkg::DivStages] = res_ready_i;
    for (int k = rhc_pkg::DivStages - 1; k >= 0; k--) begin
      rdy[k] = !valid_q[k] || rdy[k+1];
    end
  end

  assign work_ready_o = rdy[0];

  // Advance stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      for (int k = 0; k < rhc_pkg::DivStages; k++) begin
        if (rdy[k]) begin
          valid_q[k] <= src_valid[k];
        end
      end
    end
  end

  // Resolve the next quotient bits as the item moves down
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < rhc_pkg::DivStages; k++) begin
      if (rdy[k] && src_valid[k]) begin
        stage_q[k] <= rhc_pkg::div_stage(src[k]);
      end
    end
  end

  // Apply gray, black and full-saturation overrides
  always_comb begin
    res_valid_o  = valid_q[Last];
    brightness_o = stage_q[Last].brightness;
    hue_o        = stage_q[Last].hue_zero ? '0 : stage_q[Last].hue_quo;
    priority if (stage_q[Last].sat_zero) begin
      saturation_o = '0;
    end else if (stage_q[Last].sat_full) begin
      saturation_o = '1;
    end else begin
      saturation_o = stage_q[Last].sat_quo;
    end
  end

endmodule

>>> hw/rtl/rgb_to_hsv_converter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter: streaming RGB to HSV pixel converter
// Converts 8-bit RGB pixels to 16-bit hue, 16-bit saturation and 8-bit value.
// ----------------------------------------------------------------------------
// Takes one pixel per clock unless stalled and returns one HSV result per
// pixel, in order. A pixel passes the classifier register, the four-entry
// work queue and the divider pipeline, which resolves two quotient bits
// of hue and of saturation in each stage.
// Throughput stays at one pixel per clock as long as the output is taken;
// the queue lets the input keep flowing while the output stalls, until full.
// Hue is a fraction of a turn (65536 is one turn), saturation is chroma over
// value as a 16-bit fraction clamped to 65535, and both are zero for a gray
// or black pixel.
module rgb_to_hsv_converter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // red [7:0], green [15:8], blue [23:16]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata    // hue [15:0], saturation [31:16],
                                      // brightness [39:32]
);

  logic                        work_valid;
  logic                        work_ready;
  rhc_pkg::work_t              work;
  logic                        queue_valid;
  logic                        queue_ready;
  rhc_pkg::work_t              queue_data;
  logic [rhc_pkg::QuoW-1:0]    hue;
  logic [rhc_pkg::QuoW-1:0]    saturation;
  logic [rhc_pkg::ChanW-1:0]   brightness;

  rhc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pix_valid_i  (s_axis_tvalid),
    .pix_ready_o  (s_axis_tready),
    .red_i        (s_axis_tdata[7:0]),
    .green_i      (s_axis_tdata[15:8]),
    .blue_i       (s_axis_tdata[23:16]),
    .work_valid_o (work_valid),
    .work_ready_i (work_ready),
    .work_o       (work)
  );

  rhc_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (work_valid),
    .in_ready_o  (work_ready),
    .in_data_i   (work),
    .out_valid_o (queue_valid),
    .out_ready_i (queue_ready),
    .out_data_o  (queue_data)
  );

  rhc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .work_valid_i (queue_valid),
    .work_ready_o (queue_ready),
    .work_i       (queue_data),
    .res_valid_o  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready),
    .hue_o        (hue),
    .saturation_o (saturation),
    .brightness_o (brightness)
  );

  assign m_axis_tdata = {brightness, saturation, hue};

`ifndef SYNTHESIS
  // A black pixel has neither hue nor saturation
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[39:32] == 8'd0) |->
      (m_axis_tdata[31:16] == 16'd0) && (m_axis_tdata[15:0] == 16'd0))
    else $error("black pixel with nonzero hue or saturation");

  // Any hue implies nonzero chroma, hence nonzero saturation
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[15:0] != 16'd0) |->
      (m_axis_tdata[31:16] != 16'd0))
    else $error("nonzero hue with zero saturation");

  // No result is offered while in reset
  assert property (@(posedge clk_i) !rst_ni |-> !m_axis_tvalid)
    else $error("result valid during reset");
`endif

endmodule

>>> test/hsv_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv_result_checker: scoreboard for the RGB to HSV converter
// Watches both stream ports, computes the HSV form of every pixel transfer
// and compares each result transfer, field by field, with the oldest one.
// ----------------------------------------------------------------------------
module hsv_result_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  logic [3*rhc_pkg::ChanW-1:0]   in_data_i,   // red, green, blue
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  logic [2*rhc_pkg::QuoW+rhc_pkg::ChanW-1:0] out_data_i,
  output int                            fail_count_o,
  output int                            pending_o
);

  localparam int HueSectors  = 6;
  localparam int GreenOffset = 2;
  localparam int BlueOffset  = 4;
  localparam int FracOne     = 65536;
  localparam int FracMax     = 65535;

  // Result layout, highest field first: brightness, saturation, hue
  typedef struct packed {
    logic [rhc_pkg::ChanW-1:0] brightness;
    logic [rhc_pkg::QuoW-1:0]  saturation;
    logic [rhc_pkg::QuoW-1:0]  hue;
  } hsv_t;

  hsv_t expected_hsv_q[$];
  int   fail_count;

  assign fail_count_o = fail_count;
  assign pending_o    = expected_hsv_q.size();

  // Integer six-sector conversion of one pixel
  function automatic hsv_t predict_hsv(input logic [rhc_pkg::ChanW-1:0] red,
                                       input logic [rhc_pkg::ChanW-1:0] green,
                                       input logic [rhc_pkg::ChanW-1:0] blue);
    hsv_t res;
    int   r;
    int   g;
    int   b;
    int   v;
    int   lo;
    int   chroma;
    int   sat;
    int   hue;
    int   pos;
    r  = red;
    g  = green;
    b  = blue;
    v  = (r > g) ? r : g;
    v  = (v > b) ? v : b;
    lo = (r < g) ? r : g;
    lo = (lo < b) ? lo : b;
    chroma = v - lo;
    sat = 0;
    hue = 0;
    if (v != 0) begin
      sat = (chroma * FracOne) / v;
      if (sat > FracMax) sat = FracMax;
    end
    if (chroma != 0) begin
      // Ties for the largest channel go to red, then green
      if (r == v) begin
        pos = g - b;
      end else if (g == v) begin
        pos = GreenOffset * chroma + (b - r);
      end else begin
        pos = BlueOffset * chroma + (r - g);
      end
      // Wrap a negative position by one full turn
      if (pos < 0) pos += HueSectors * chroma;
      hue = (pos * FracOne) / (HueSectors * chroma);
      if (hue > FracMax) hue = FracMax;
    end
    res.brightness = v[rhc_pkg::ChanW-1:0];
    res.saturation = sat[rhc_pkg::QuoW-1:0];
    res.hue        = hue[rhc_pkg::QuoW-1:0];
    return res;
  endfunction

  // Score result transfers, then queue the prediction for a pixel transfer
  always @(posedge clk_i or negedge rst_ni) begin
    hsv_t got;
    hsv_t want;
    if (!rst_ni) begin
      expected_hsv_q.delete();
      fail_count = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        got = hsv_t'(out_data_i);
        if (expected_hsv_q.size() == 0) begin
          $display("%0t: unexpected result transfer %h", $time, out_data_i);
          fail_count++;
        end else begin
          want = expected_hsv_q.pop_front();
          if (got.hue !== want.hue) begin
            $display("%0t: hue mismatch, expected %h, actual %h",
                     $time, want.hue, got.hue);
            fail_count++;
          end
          if (got.saturation !== want.saturation) begin
            $display("%0t: saturation mismatch, expected %h, actual %h",
                     $time, want.saturation, got.saturation);
            fail_count++;
          end
          if (got.brightness !== want.brightness) begin
            $display("%0t: brightness mismatch, expected %h, actual %h",
                     $time, want.brightness, got.brightness);
            fail_count++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        expected_hsv_q.push_back(predict_hsv(in_data_i[7:0], in_data_i[15:8],
                                             in_data_i[23:16]));
      end
    end
  end

endmodule

>>> test/tb_rgb_to_hsv_converter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rgb_to_hsv_converter: stream test of the RGB to HSV converter
// Sends directed corner pixels, then biased random pixels under three idling
// mixes and one long output stall; a scoreboard checks every result.
// ----------------------------------------------------------------------------
module tb_rgb_to_hsv_converter;

  localparam int LongHoldCycles = 60;
  localparam int DrainCycles    = 30;
  localparam int ChanMax        = (1 << rhc_pkg::ChanW) - 1;

  // Random pixel shapes
  typedef enum int {
    PixGray,
    PixZeroChan,
    PixTiedMax,
    PixFullChan,
    PixUniform
  } pix_kind_e;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;   // red [7:0], green [15:8], blue [23:16]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;   // hue [15:0], saturation [31:16],
                               // brightness [39:32]

  int fail_count;
  int pending;
  int send_idle_pct;
  int recv_idle_pct;
  bit long_hold_req;

  rgb_to_hsv_converter DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  hsv_result_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_i   (s_axis_tready),
    .in_data_i    (s_axis_tdata),
    .out_valid_i  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_data_i   (m_axis_tdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Free-running clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Hard stop for a hung run
  initial begin
    #4ms;
    $display("TEST FAILED");
    $finish;
  end

  // Result side: random backpressure, plus one long hold on request
  initial begin
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (LongHoldCycles) @(negedge clk_i);
      end
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Offer one pixel after random gaps and hold it until it transfers
  task automatic send_pixel(input logic [7:0] red, input logic [7:0] green,
                            input logic [7:0] blue);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {blue, green, red};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Pixel biased toward gray, clipped, tied and full-scale shapes
  task automatic send_random_pixel();
    logic [7:0] ch[3];
    int         pick;
    int         other;
    pix_kind_e  kind;
    for (int i = 0; i < 3; i++) ch[i] = 8'($urandom_range(ChanMax));
    pick  = $urandom_range(2);
    other = (pick + 1 + $urandom_range(1)) % 3;
    case ($urandom_range(8))
      0:       kind = PixGray;
      1:       kind = PixZeroChan;
      2, 3:    kind = PixTiedMax;
      4:       kind = PixFullChan;
      default: kind = PixUniform;
    endcase
    case (kind)
      PixGray: begin
        ch[1] = ch[0];
        ch[2] = ch[0];
      end
      PixZeroChan: ch[pick] = 8'd0;
      PixTiedMax: begin
        if (ch[3 - pick - other] > ch[pick]) begin
          ch[pick] = ch[3 - pick - other];
        end
        ch[other] = ch[pick];
      end
      PixFullChan: ch[pick] = 8'(ChanMax);
      default: ;
    endcase
    send_pixel(ch[0], ch[1], ch[2]);
  endtask

  // Reset, directed corners, three random phases, drain and verdict
  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    long_hold_req = 1'b0;
    send_idle_pct = 30;
    recv_idle_pct = 54;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Black, white and gray
    send_pixel(8'd0,   8'd0,   8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd128, 8'd128, 8'd128);
    send_pixel(8'd1,   8'd1,   8'd1);
    // Pure primaries and secondaries, with ties for the largest channel
    send_pixel(8'd255, 8'd0,   8'd0);
    send_pixel(8'd0,   8'd255, 8'd0);
    send_pixel(8'd0,   8'd0,   8'd255);
    send_pixel(8'd255, 8'd255, 8'd0);
    send_pixel(8'd0,   8'd255, 8'd255);
    send_pixel(8'd255, 8'd0,   8'd255);
    // Red largest with green below blue wraps past zero
    send_pixel(8'd255, 8'd0,   8'd1);
    send_pixel(8'd200, 8'd10,  8'd199);
    // Smallest nonzero chroma and value
    send_pixel(8'd1,   8'd0,   8'd0);
    send_pixel(8'd0,   8'd0,   8'd1);
    send_pixel(8'd255, 8'd254, 8'd254);
    send_pixel(8'd254, 8'd255, 8'd255);
    // Samples in five of the six sectors
    send_pixel(8'd200, 8'd100, 8'd50);
    send_pixel(8'd100, 8'd200, 8'd50);
    send_pixel(8'd50,  8'd200, 8'd100);
    send_pixel(8'd50,  8'd100, 8'd200);
    send_pixel(8'd100, 8'd50,  8'd200);
    send_pixel(8'd170, 8'd85,  8'd0);
    send_pixel(8'd2,   8'd3,   8'd1);

    repeat (400) send_random_pixel();

    send_idle_pct = 54;
    recv_idle_pct = 30;
    repeat (400) send_random_pixel();

    // No idling; stall the output long enough to back up the input
    send_idle_pct = 0;
    recv_idle_pct = 0;
    long_hold_req = 1'b1;
    repeat (300) send_random_pixel();

    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
